/* sv/vnig_pkg.sv */
// Shared types and constants for the velvet noise impulse generator.
package vnig_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 3;
    localparam int CNT_W    = 7;
    localparam int PH_W     = 25;
    localparam int FRAC_W   = 24;

    localparam logic [PH_W-1:0] ONE_Q24   = PH_W'(1) << FRAC_W;
    localparam logic [31:0]     SP_RESET  = 32'd89478;

    localparam logic [1:0] IMP_ZERO = 2'b00;
    localparam logic [1:0] IMP_POS  = 2'b01;
    localparam logic [1:0] IMP_NEG  = 2'b11;

    typedef logic [CH_AW-1:0] t_addr;

    // per-channel state word
    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic [PH_W-1:0] prev;
        logic            pstart;
        logic [PH_W-1:0] pos;
    } t_entry;

    // registered front-end results for one beat
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            freq_pos;
        logic [63:0]     prod;
        logic            sign_pos;
        logic [PH_W-1:0] new_pos;
    } t_prep;

endpackage

/* sv/velvet_noise_impulse_generator_top.sv */
// Top level of the multichannel velvet noise impulse generator.
//
//  channel   dir  beat fields (tuser / tdata)
//  s_axis    in   tuser: channel | tdata: frequency, bias, regularity,
//                 polarity_draw, position_draw
//  m_axis    out  tuser: out_channel | tdata: impulse
//  cfg       in   sample_period, written when i_cfg_wr_en is high
//
// One beat per cycle sustained while m_axis is ready. The output beat passes
// the front-end register with the memory read, then the update and output
// register, before it is valid on m_axis. The state memory read-modify-write
// sets the rate; a bypass covers a beat that reads the channel written on the
// same edge.
// Reset clears per-entry valid bits at once, so no clearing pass is needed;
// s_axis is not ready while reset is held.
// A stall on m_axis holds the update stage and then the input.
module velvet_noise_impulse_generator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [31:0] frequency, [49:32] bias, [67:50] regularity,
    // [83:68] polarity_draw, [99:84] position_draw, [103:100] zero
    input  logic [103:0]  i_s_axis_tdata,
    // [2:0] channel
    input  logic [2:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [1:0] impulse, [7:2] zero
    output logic [7:0]    o_m_axis_tdata,
    // [2:0] out_channel
    output logic [2:0]    o_m_axis_tuser,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data
);

    logic [31:0]      r_sample_period;
    logic             r_s1_vld;
    logic             r_out_vld;
    logic [2:0]       r_out_ch;
    logic [1:0]       r_out_imp;

    logic             w_s_accept;
    logic             w_s1_fire;
    logic             w_in_range;
    logic             w_wr_en;
    logic [1:0]       w_impulse;
    logic [1:0]       n_out_imp;

    vnig_pkg::t_prep  w_prep;
    vnig_pkg::t_entry w_cur;
    vnig_pkg::t_entry w_nxt;

    assign w_s1_fire       = r_s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_s1_vld || w_s1_fire);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_range      = vnig_pkg::CNT_W'(w_prep.ch) < vnig_pkg::CNT_W'(vnig_pkg::CHANNELS);
    assign w_wr_en         = w_s1_fire && w_in_range;
    assign n_out_imp       = w_in_range ? w_impulse : vnig_pkg::IMP_ZERO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= vnig_pkg::SP_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_period <= i_cfg_wr_data;
        end
    end

    vnig_prep u_prep (
        .i_clk           (i_clk),
        .i_en            (w_s_accept),
        .i_channel       (i_s_axis_tuser),
        .i_frequency     (i_s_axis_tdata[31:0]),
        .i_bias          (i_s_axis_tdata[49:32]),
        .i_regularity    (i_s_axis_tdata[67:50]),
        .i_polarity_draw (i_s_axis_tdata[83:68]),
        .i_position_draw (i_s_axis_tdata[99:84]),
        .i_sample_period (r_sample_period),
        .o_prep          (w_prep)
    );

    vnig_chan_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_s_accept),
        .i_rd_addr (vnig_pkg::t_addr'(i_s_axis_tuser)),
        .o_rd_data (w_cur),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (vnig_pkg::t_addr'(w_prep.ch)),
        .i_wr_data (w_nxt)
    );

    vnig_update u_update (
        .i_prep    (w_prep),
        .i_cur     (w_cur),
        .o_nxt     (w_nxt),
        .o_impulse (w_impulse)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out_ch  <= w_prep.ch;
            r_out_imp <= n_out_imp;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out_imp};
    assign o_m_axis_tuser  = r_out_ch;

    a_imp_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] != 2'b10))
        else $error("impulse code out of range");

    a_phase_wrapped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_nxt.prev[vnig_pkg::FRAC_W])
        else $error("stored phase not below one after wrap");

    a_fire_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire |=> o_m_axis_tvalid)
        else $error("update stage fired but no output beat");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_fire) |=> (r_s1_vld && $stable(w_prep.ch)))
        else $error("stalled update stage lost its beat");

endmodule

/* sv/vnig_prep.sv */
// Front-end stage: step product, clipped bias compare and next impulse position.
module vnig_prep (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [vnig_pkg::CH_W-1:0] i_channel,
    input  logic signed [31:0]        i_frequency,
    input  logic signed [17:0]        i_bias,
    input  logic signed [17:0]        i_regularity,
    input  logic [15:0]               i_polarity_draw,
    input  logic [15:0]               i_position_draw,
    input  logic [31:0]               i_sample_period,
    output vnig_pkg::t_prep           o_prep
);

    function automatic logic [16:0] clip_unit(input logic signed [17:0] v);
        logic [16:0] r;
        if (v[17]) begin
            r = 17'd0;
        end else if (v > 18'sd65536) begin
            r = 17'd65536;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    logic [16:0] w_bias;
    logic [16:0] w_reg;
    logic [16:0] w_span;
    logic [32:0] w_pos_prod;
    logic [63:0] w_prod;

    vnig_pkg::t_prep r_prep;

    assign w_bias     = clip_unit(i_bias);
    assign w_reg      = clip_unit(i_regularity);
    assign w_span     = 17'd65536 - w_reg;
    assign w_pos_prod = 33'(i_position_draw) * 33'(w_span);
    assign w_prod     = 64'($unsigned(i_frequency)) * 64'(i_sample_period);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep.ch       <= i_channel;
            r_prep.freq_pos <= (i_frequency > 32'sd0);
            r_prep.prod     <= w_prod;
            r_prep.sign_pos <= (17'(i_polarity_draw) > w_bias);
            r_prep.new_pos  <= w_pos_prod[32:8];
        end
    end

    assign o_prep = r_prep;

endmodule

/* sv/vnig_chan_mem.sv */
// Per-channel state memory: registered read, entry valid bits, last-write bypass.
module vnig_chan_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  vnig_pkg::t_addr  i_rd_addr,
    output vnig_pkg::t_entry o_rd_data,
    input  logic             i_wr_en,
    input  vnig_pkg::t_addr  i_wr_addr,
    input  vnig_pkg::t_entry i_wr_data
);

    vnig_pkg::t_entry mem [vnig_pkg::CHANNELS];

    logic [vnig_pkg::CHANNELS-1:0] r_ent_vld;
    vnig_pkg::t_entry              r_rd_data;
    logic                          r_rd_vld;
    vnig_pkg::t_addr               r_rd_addr;
    logic                          r_byp_vld;
    vnig_pkg::t_addr               r_byp_addr;
    vnig_pkg::t_entry              r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_byp_addr <= i_wr_addr;
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_ent_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
                r_byp_vld            <= 1'b1;
            end
        end
    end

    // a write on the same edge as the read is missed by the array; the
    // bypass always holds the newest write, so it is safe to prefer it
    always_comb begin
        if (r_byp_vld && (r_byp_addr == r_rd_addr)) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

/* sv/vnig_update.sv */
// Phase update: impulse decision, wrap and next state for one channel.
module vnig_update (
    input  vnig_pkg::t_prep  i_prep,
    input  vnig_pkg::t_entry i_cur,
    output vnig_pkg::t_entry o_nxt,
    output logic [1:0]       o_impulse
);

    logic [vnig_pkg::PH_W-1:0] w_step;
    logic [vnig_pkg::PH_W-1:0] w_ph;
    logic                      w_wrap;
    logic                      w_hit;

    always_comb begin
        if (!i_prep.freq_pos) begin
            w_step = '0;
        end else if (i_prep.prod[63:20] > 44'(vnig_pkg::ONE_Q24)) begin
            w_step = vnig_pkg::ONE_Q24;
        end else begin
            w_step = i_prep.prod[44:20];
        end
    end

    assign w_hit  = (i_cur.phase >= i_cur.pos) &&
                    ((i_cur.prev < i_cur.pos) || i_cur.pstart);
    assign w_wrap = i_cur.phase[vnig_pkg::FRAC_W];
    assign w_ph   = w_wrap ? {1'b0, i_cur.phase[vnig_pkg::FRAC_W-1:0]} : i_cur.phase;

    always_comb begin
        o_nxt.pstart = w_wrap;
        o_nxt.pos    = w_wrap ? i_prep.new_pos : i_cur.pos;
        o_nxt.prev   = w_ph;
        o_nxt.phase  = w_ph + w_step;
    end

    always_comb begin
        if (!w_hit) begin
            o_impulse = vnig_pkg::IMP_ZERO;
        end else if (i_prep.sign_pos) begin
            o_impulse = vnig_pkg::IMP_POS;
        end else begin
            o_impulse = vnig_pkg::IMP_NEG;
        end
    end

endmodule
